// ----- rtl/lifo_stack_with_reverse_defines.svh -----
// Assertion macros used by the checker file of the stack.
`ifndef LIFO_STACK_WITH_REVERSE_DEFINES_SVH
`define LIFO_STACK_WITH_REVERSE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LSR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lifo stack check failed");

// Next-cycle implication, disabled during reset.
`define LSR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lifo stack check failed");

`endif

// ----- rtl/lsr_pkg.sv -----
`default_nettype none
package lsr_pkg;

  // Default sizing
  localparam int DEPTH_DEF      = 256;
  localparam int WORD_WIDTH_DEF = 32;

  // Fixed field widths of the transaction payloads
  localparam int OP_W    = 3;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 9;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
  localparam logic [OP_W-1:0] OP_POP     = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd3;
  localparam logic [OP_W-1:0] OP_REVERSE = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic signed [VALUE_W-1:0] push_value;
  } cmd_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic                      ok;
    logic [COUNT_W-1:0]        count;
    logic                      is_empty;
    logic                      is_full;
  } rsp_t;

endpackage
`default_nettype wire

// ----- rtl/lsr_store.sv -----
`default_nettype none
module lsr_store #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lifo_stack_with_reverse.sv -----
`default_nettype none
// Bounded LIFO stack of signed words with push, pop, peek, clear and an O(1)
// reverse. Every command transaction returns exactly one response carrying the
// popped or peeked word (zero otherwise), a success flag and the count, empty
// and full status after the operation. Entries live in a DEPTH-slot ring RAM
// occupied from a base pointer; an orientation bit picks which end of the span
// is the top, so reverse just flips that bit. A command is accepted in the
// cycle it is offered unless a response is backed up, giving one transaction
// per cycle; each passes through the pointer update and RAM access, then the
// response register. A RAM read never collides with the write of an earlier
// command, and one command never both reads and writes, so no forwarding is
// needed. The RAM has no reset and needs no clearing pass.
module lifo_stack_with_reverse #(
  parameter int DEPTH      = lsr_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = lsr_pkg::WORD_WIDTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cmd_valid,
  output logic              cmd_stall,
  input  wire lsr_pkg::cmd_t cmd,
  output logic              rsp_valid,
  input  wire logic         rsp_stall,
  output lsr_pkg::rsp_t     rsp
);

  import lsr_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  // Ring pointers
  logic [AW-1:0] base, base_next;
  logic [CW-1:0] count, count_next;
  logic          rev, rev_next;

  // First stage: operation done, waiting on RAM data
  logic          s1_valid;
  logic          s1_ok;
  logic          s1_rd;
  logic [CW-1:0] s1_count;

  logic          accept, advance;
  logic          full, empty;
  logic          op_ok;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [WORD_WIDTH-1:0] wr_data, rd_data;

  logic [SW-1:0] end_sum, top_sum;
  logic [AW-1:0] push_slot, top_slot, base_dec, base_inc;
  logic [63:0]   push_wide;
  logic signed [63:0] rd_wide;

  assign accept  = cmd_valid && !cmd_stall;
  assign advance = !rsp_valid || !rsp_stall;
  assign cmd_stall = s1_valid && !advance;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  // Ring arithmetic; sums stay below twice DEPTH
  assign end_sum   = SW'(base) + SW'(count);
  assign top_sum   = end_sum - SW'(1);
  assign push_slot = (end_sum >= SW'(DEPTH)) ? AW'(end_sum - SW'(DEPTH)) : AW'(end_sum);
  assign top_slot  = (top_sum >= SW'(DEPTH)) ? AW'(top_sum - SW'(DEPTH)) : AW'(top_sum);
  assign base_dec  = (base == '0) ? AW'(DEPTH - 1) : base - AW'(1);
  assign base_inc  = (base == AW'(DEPTH - 1)) ? '0 : base + AW'(1);

  // Pushed words keep their low bits
  assign push_wide = {32'b0, cmd.push_value};
  assign wr_data   = push_wide[WORD_WIDTH-1:0];

  // Operation decode and pointer update
  always_comb begin
    base_next  = base;
    count_next = count;
    rev_next   = rev;
    op_ok      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = push_slot;
    rd_en      = 1'b0;
    rd_addr    = rev ? base : top_slot;
    case (cmd.operation)
      OP_PUSH: begin
        if (!full) begin
          op_ok      = 1'b1;
          wr_en      = accept;
          count_next = count + CW'(1);
          if (rev) begin
            base_next = base_dec;
            wr_addr   = base_dec;
          end
        end
      end
      OP_POP, OP_PEEK: begin
        if (!empty) begin
          op_ok = 1'b1;
          rd_en = accept;
          if (cmd.operation == OP_POP) begin
            count_next = count - CW'(1);
            if (rev) begin
              base_next = base_inc;
            end
          end
        end
      end
      OP_CLEAR: begin
        op_ok      = 1'b1;
        count_next = '0;
      end
      OP_REVERSE: begin
        op_ok    = 1'b1;
        rev_next = ~rev;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  lsr_store #(
    .DEPTH (DEPTH),
    .WIDTH (WORD_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Pointer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base  <= '0;
      count <= '0;
      rev   <= 1'b0;
    end else if (accept) begin
      base  <= base_next;
      count <= count_next;
      rev   <= rev_next;
    end
  end

  // Stage one control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok    <= op_ok;
      s1_rd    <= rd_en;
      s1_count <= count_next;
    end
  end

  // Read words are sign-extended from the stored width
  assign rd_wide = 64'(signed'(rd_data));

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= (s1_valid && advance) || (rsp_valid && rsp_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      rsp.read_value <= s1_rd ? signed'(rd_wide[VALUE_W-1:0]) : '0;
      rsp.ok         <= s1_ok;
      rsp.count      <= COUNT_W'(s1_count);
      rsp.is_empty   <= (s1_count == '0);
      rsp.is_full    <= (s1_count == CW'(DEPTH));
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lsr_checker.sv -----
`default_nettype none
`include "lifo_stack_with_reverse_defines.svh"
module lsr_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          cmd_valid,
  input wire logic          cmd_stall,
  input wire lsr_pkg::cmd_t cmd,
  input wire logic          rsp_valid,
  input wire logic          rsp_stall,
  input wire lsr_pkg::rsp_t rsp
);

  import lsr_pkg::*;

  // A stalled response holds
  `LSR_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // Full and empty never show together
  `LSR_ASSERT_IMP(a_full_not_empty, rsp_valid && rsp.is_full, !rsp.is_empty)

  // Empty status always reports a zero count
  `LSR_ASSERT_IMP(a_empty_count, rsp_valid && rsp.is_empty, rsp.count == '0)

  // A failed operation returns no data
  `LSR_ASSERT_IMP(a_fail_zero, rsp_valid && !rsp.ok, rsp.read_value == '0)

endmodule

bind lifo_stack_with_reverse lsr_checker u_lsr_checker (.*);
`default_nettype wire

// ----- dv/lifo_stack_with_reverse_tb.sv -----
`default_nettype none
module lifo_stack_with_reverse_tb;
  import lsr_pkg::*;

  localparam int STACK_DEPTH = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1330;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  // Operation codes the block does not implement
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_LAST = 3'd7;

  // Shadow copy of the stack: ring slots, base pointer, fill level, orientation
  class stack_shadow;
    logic [VALUE_W-1:0] slots [STACK_DEPTH];
    logic [7:0] base = '0;
    logic [COUNT_W-1:0] used = '0;
    bit flipped;
    rsp_t awaited_rsp [$];
    int errors;

    // Apply one accepted command and queue the response it should produce
    function void apply_cmd(cmd_t c);
      rsp_t e;
      logic [7:0] slot;
      e = '0;
      case (c.operation)
        OP_PUSH: begin
          if (used < STACK_DEPTH) begin
            if (flipped) begin
              base = base - 8'd1;
              slot = base;
            end else begin
              slot = base + used[7:0];
            end
            slots[slot] = c.push_value;
            used = used + 1'b1;
            e.ok = 1'b1;
          end
        end
        OP_POP, OP_PEEK: begin
          if (used != 0) begin
            slot = flipped ? base : base + used[7:0] - 8'd1;
            e.read_value = slots[slot];
            e.ok = 1'b1;
            if (c.operation == OP_POP) begin
              if (flipped) base = base + 8'd1;
              used = used - 1'b1;
            end
          end
        end
        OP_CLEAR: begin
          used = '0;
          e.ok = 1'b1;
        end
        OP_REVERSE: begin
          flipped = ~flipped;
          e.ok = 1'b1;
        end
        default: ;
      endcase
      e.count = used;
      e.is_empty = (used == 0);
      e.is_full = (used == STACK_DEPTH);
      awaited_rsp.push_back(e);
    endfunction

    // Compare a response against the oldest queued expectation
    function void compare_rsp(rsp_t r);
      rsp_t e;
      if (awaited_rsp.size() == 0) begin
        $error("response with nothing outstanding: read_value %0d", r.read_value);
        errors++;
        return;
      end
      e = awaited_rsp.pop_front();
      if (r.read_value !== e.read_value) begin
        $error("read_value: expected %0d, got %0d", e.read_value, r.read_value);
        errors++;
      end
      if (r.ok !== e.ok) begin
        $error("ok: expected %0b, got %0b", e.ok, r.ok);
        errors++;
      end
      if (r.count !== e.count) begin
        $error("count: expected %0d, got %0d", e.count, r.count);
        errors++;
      end
      if (r.is_empty !== e.is_empty) begin
        $error("is_empty: expected %0b, got %0b", e.is_empty, r.is_empty);
        errors++;
      end
      if (r.is_full !== e.is_full) begin
        $error("is_full: expected %0b, got %0b", e.is_full, r.is_full);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  stack_shadow sb = new;
  bit steady = 1'b0;  // when set, neither side inserts idle cycles
  int sent = 0;

  lifo_stack_with_reverse dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Offer one command, hold it until accepted, then record it
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val);
    int gap;
    cmd_t c;
    c.operation = op;
    c.push_value = val;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (cmd_stall);
    sb.apply_cmd(c);
    sent++;
  endtask

  // Random operation with a given push/pop bias
  task automatic send_mixed(input int push_pct, input int pop_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct)
      send_cmd(OP_PUSH, $urandom);
    else if (roll < push_pct + pop_pct)
      send_cmd(OP_POP, $urandom);
    else if (roll < push_pct + pop_pct + 12)
      send_cmd(OP_PEEK, $urandom);
    else if (roll < push_pct + pop_pct + 18)
      send_cmd(OP_REVERSE, $urandom);
    else if (roll < push_pct + pop_pct + 20)
      send_cmd(OP_CLEAR, $urandom);
    else
      send_cmd(OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), $urandom);
  endtask

  // Response side: random stall before each transaction
  initial begin
    int gap;
    forever begin
      gap = steady ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        rsp_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        rsp_stall <= 1'b0;
      end
      do @(posedge clk); while (!(rsp_valid === 1'b1 && !rst));
    end
  end

  // Response monitor
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.compare_rsp(rsp);
  end

  // Watchdog on cycles without any accepted transaction
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
    end
    $display("lifo_stack_with_reverse_tb: done, errors");
    $finish;
  end

  // Stimulus
  initial begin
    int mode;
    int run;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-stack failures, unused codes, extremes, reverse paths
    send_cmd(OP_PEEK, 32'h0);
    send_cmd(OP_POP, 32'h0);
    send_cmd(OP_SPARE_FIRST, 32'hFFFF_FFFF);
    send_cmd(OP_SPARE_MID, 32'h0);
    send_cmd(OP_SPARE_LAST, 32'hAAAA_5555);
    send_cmd(OP_REVERSE, 32'h0);
    send_cmd(OP_REVERSE, 32'h0);
    send_cmd(OP_PUSH, 32'h7FFF_FFFF);
    send_cmd(OP_PUSH, 32'h8000_0000);
    send_cmd(OP_PUSH, 32'h0000_0000);
    send_cmd(OP_PUSH, 32'hFFFF_FFFF);
    send_cmd(OP_PEEK, 32'h0);
    send_cmd(OP_POP, 32'h0);
    send_cmd(OP_REVERSE, 32'h0);
    send_cmd(OP_PEEK, 32'h0);
    send_cmd(OP_POP, 32'h0);
    send_cmd(OP_PUSH, 32'h1234_5678);
    send_cmd(OP_POP, 32'h0);
    send_cmd(OP_REVERSE, 32'h0);
    send_cmd(OP_POP, 32'h0);
    send_cmd(OP_CLEAR, 32'h0);
    send_cmd(OP_POP, 32'h0);
    send_cmd(OP_PUSH, 32'h5555_AAAA);
    send_cmd(OP_CLEAR, 32'h0);

    // Random phases: fill to full, drain to empty, or biased mixed runs
    while (sent < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 9);
      if (mode < 2) begin
        while (sb.used < STACK_DEPTH) begin
          if ($urandom_range(0, 19) == 0) send_cmd(OP_REVERSE, $urandom);
          else send_cmd(OP_PUSH, $urandom);
        end
        repeat ($urandom_range(1, 3)) send_cmd(OP_PUSH, $urandom);
        send_cmd(OP_PEEK, $urandom);
      end else if (mode == 2) begin
        while (sb.used != 0) begin
          if ($urandom_range(0, 9) == 0) send_cmd(OP_REVERSE, $urandom);
          else send_cmd(OP_POP, $urandom);
        end
        send_cmd(OP_POP, $urandom);
        send_cmd(OP_PEEK, $urandom);
      end else begin
        run = $urandom_range(20, 80);
        repeat (run) begin
          if (mode < 6) send_mixed(50, 25);
          else send_mixed(30, 45);
        end
      end
    end

    cmd_valid <= 1'b0;
    steady = 1'b0;
    while (sb.awaited_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("lifo_stack_with_reverse_tb: done, clean");
    else
      $display("lifo_stack_with_reverse_tb: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
